>>> src/lprf_pkg.sv
package lprf_pkg;

    // default geometry
    localparam int QUEUE_BYTES_DEF  = 4096;
    localparam int RECORD_BYTES_DEF = 1024;
    localparam int HEADER_BYTES     = 4;

    // payload widths
    localparam int MLEN_W   = 24;
    localparam int BYTE_W   = 8;
    localparam int CAP_W    = 24;
    localparam int RLEN_W   = 11;
    localparam int DCNT_W   = 32;
    localparam int HDR_W    = 32;

    // APB side
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;
    localparam int PIDX_W   = PADDR_W - 2;
    localparam logic [PIDX_W-1:0] REG_CAPTURE_ON = '0;

    typedef enum logic [1:0] {
        KIND_MSG_START = 2'd0,
        KIND_MSG_BYTE  = 2'd1,
        KIND_POP_START = 2'd2,
        KIND_POP_BYTE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_READY     = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_BUSY      = 3'd5,
        ST_NONE_OPEN = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_HDR,
        S_SKIP,
        S_HRD,
        S_EXEC
    } t_state;

endpackage

>>> src/lprf_if.sv
interface lprf_req_if import lprf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [MLEN_W-1:0]    message_length;
    logic [BYTE_W-1:0]    in_byte;
    logic [CAP_W-1:0]     reader_capacity;

    modport source (output valid, kind, message_length, in_byte, reader_capacity,
                    input ready);
    modport sink   (input valid, kind, message_length, in_byte, reader_capacity,
                    output ready);
endinterface

interface lprf_rsp_if import lprf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [RLEN_W-1:0]    rec_len;
    logic [DCNT_W-1:0]    dropped_count;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last;

    modport source (output valid, status, rec_len, dropped_count, out_byte, last,
                    input ready);
    modport sink   (input valid, status, rec_len, dropped_count, out_byte, last,
                    output ready);
endinterface

>>> src/lprf_ram.sv
module lprf_ram import lprf_pkg::*; #(
    parameter int DEPTH = QUEUE_BYTES_DEF,
    parameter int AW    = $clog2(QUEUE_BYTES_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/length_prefixed_record_fifo.sv
// Byte ring FIFO of length-prefixed records.
// i_req (sink) carries one command per transfer: message start, message byte,
// pop start or pop byte. o_rsp (source) returns exactly one result transfer per
// command, in order. The capture_on register sits behind a small APB port and
// is to be written only while the block is idle; the block does not enforce it.
// Commands are handled one at a time. A message start passes the multiply step
// before it executes; a message byte that opens a chunk first writes the 4-byte
// header; a pop start with no message open first discards any unread tail and
// reads the header. The single byte-wide ring memory does one write and one read
// per cycle, with read data registered into the cycle after the address.
// The admission check uses a 24x25 reciprocal multiply for the chunk count,
// registered before the compare.
// Reset clears pointers, counters, flags and capture_on; the ring memory needs
// no clearing since only written bytes are ever read.
// A finished result sits in the o_rsp output register. The next command is
// taken while it waits; a command that finishes while the register is still
// full holds in its last step until o_rsp is taken.
module length_prefixed_record_fifo import lprf_pkg::*; #(
    parameter int QUEUE_BYTES  = QUEUE_BYTES_DEF,
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lprf_req_if.sink           i_req,
    lprf_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int PW    = $clog2(QUEUE_BYTES);          // ring address
    localparam int UW    = $clog2(QUEUE_BYTES + 1);      // fill level
    localparam int CW    = $clog2(RECORD_BYTES + 1);     // chunk / record count
    localparam int RL    = $clog2(RECORD_BYTES);
    localparam int MULW  = MLEN_W + 1;
    localparam int PRODW = MLEN_W + MULW;
    localparam int NEEDW = MLEN_W + 4;
    // ceil(2^(24+RL) / RECORD_BYTES): exact floor division of any 24-bit value
    localparam logic [63:0] RECIP =
        ((64'd1 << (MLEN_W + RL)) + 64'(RECORD_BYTES) - 64'd1) / 64'(RECORD_BYTES);
    localparam logic [UW:0] QSIZE = (UW + 1)'(QUEUE_BYTES);

    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p,
                                             input logic [UW-1:0] n);
        logic [UW:0] s;
        s = (UW + 1)'(p) + (UW + 1)'(n);
        if (s >= QSIZE) begin
            s = s - QSIZE;
        end
        return s[PW-1:0];
    endfunction

    // control state
    t_state             r_state, n_state;
    logic [2:0]         r_cnt, n_cnt;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [UW-1:0]      r_used, n_used;
    logic [DCNT_W-1:0]  r_dropped, n_dropped;
    logic [MLEN_W-1:0]  r_msg_left, n_msg_left;
    logic [CW-1:0]      r_chunk_left, n_chunk_left;
    logic [CW-1:0]      r_rec_left, n_rec_left;
    logic               r_msg_open, n_msg_open;
    logic               r_rec_open, n_rec_open;
    logic               r_capture_on;
    logic               r_out_valid, n_out_valid;

    // command and work registers (no reset)
    t_kind              r_kind;
    logic [MLEN_W-1:0]  r_mlen;
    logic [BYTE_W-1:0]  r_byte;
    logic [CAP_W-1:0]   r_cap;
    logic [PRODW-1:0]   r_prod;
    logic [HDR_W-1:0]   r_hdr;

    // output register
    t_status            r_status, n_status;
    logic [RLEN_W-1:0]  r_rlen, n_rlen;
    logic [DCNT_W-1:0]  r_dcount, n_dcount;
    logic [BYTE_W-1:0]  r_obyte, n_obyte;
    logic               r_last, n_last;

    // memory port
    logic               mem_we;
    logic [PW-1:0]      mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [PW-1:0]      mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    // datapath helpers
    logic               req_xfer;
    logic               res_go;
    logic               cfg_write;
    logic [MLEN_W-1:0]  quot;
    logic [NEEDW-1:0]   need;
    logic [UW-1:0]      free_bytes;
    logic [CW-1:0]      chunk_len;
    logic [HDR_W-1:0]   hdr_word;
    logic [UW-1:0]      skip;
    logic [DCNT_W:0]    drop_sum;
    logic [1:0]         hdr_idx;

    assign req_xfer  = i_req.valid && i_req.ready;
    // result register free this cycle
    assign res_go    = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);

    // chunk count = floor((len - 1) / RECORD_BYTES) + 1, via registered product
    assign quot       = MLEN_W'(r_prod >> (MLEN_W + RL));
    assign need       = NEEDW'(r_mlen) + ((NEEDW'(quot) + NEEDW'(1)) << 2);
    assign free_bytes = UW'(QUEUE_BYTES) - r_used;
    assign drop_sum   = (DCNT_W + 1)'(r_dropped) + (DCNT_W + 1)'(r_mlen);

    assign chunk_len = (r_msg_left > MLEN_W'(RECORD_BYTES)) ? CW'(RECORD_BYTES)
                                                            : CW'(r_msg_left);
    assign hdr_word  = HDR_W'(chunk_len);

    assign skip = (32'(r_rec_left) > 32'(r_used)) ? r_used : UW'(r_rec_left);

    assign hdr_idx = 2'(r_cnt - 3'd1);

    // header read walks rd_ptr + 0..3; otherwise keep the head byte addressed
    assign mem_raddr = (r_state == S_HRD) ? f_wrap(r_rd_ptr, UW'(r_cnt[1:0])) : r_rd_ptr;

    lprf_ram #(
        .DEPTH (QUEUE_BYTES),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    case (i_req.kind)
                        KIND_MSG_START: n_state = S_MUL;
                        KIND_MSG_BYTE: begin
                            n_state = (r_msg_open && r_chunk_left == '0) ? S_HDR : S_EXEC;
                        end
                        KIND_POP_START: n_state = r_msg_open ? S_EXEC : S_SKIP;
                        default:        n_state = S_EXEC;
                    endcase
                end
            end
            S_MUL:  n_state = S_EXEC;
            S_HDR:  n_state = (r_cnt == 3'd3) ? S_EXEC : S_HDR;
            S_SKIP: n_state = S_HRD;
            S_HRD:  n_state = (r_cnt == 3'd4) ? S_EXEC : S_HRD;
            S_EXEC: n_state = res_go ? S_IDLE : S_EXEC;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_cnt        = r_cnt;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_used       = r_used;
        n_dropped    = r_dropped;
        n_msg_left   = r_msg_left;
        n_chunk_left = r_chunk_left;
        n_rec_left   = r_rec_left;
        n_msg_open   = r_msg_open;
        n_rec_open   = r_rec_open;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_status     = r_status;
        n_rlen       = r_rlen;
        n_dcount     = r_dcount;
        n_obyte      = r_obyte;
        n_last       = r_last;
        mem_we       = 1'b0;
        mem_waddr    = r_wr_ptr;
        mem_wdata    = r_byte;

        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
            end
            S_HDR: begin
                // little-endian chunk length, one byte per cycle
                mem_we    = 1'b1;
                mem_wdata = hdr_word[8*r_cnt[1:0] +: 8];
                n_wr_ptr  = f_wrap(r_wr_ptr, UW'(1));
                n_used    = r_used + UW'(1);
                n_cnt     = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_chunk_left = chunk_len;
                    n_cnt        = '0;
                end
            end
            S_SKIP: begin
                // discard the unread tail of an open record
                if (r_rec_open) begin
                    n_rd_ptr   = f_wrap(r_rd_ptr, skip);
                    n_used     = r_used - skip;
                    n_rec_left = '0;
                    n_rec_open = 1'b0;
                end
                n_cnt = '0;
            end
            S_HRD: begin
                n_cnt = (r_cnt == 3'd4) ? 3'd0 : r_cnt + 3'd1;
            end
            S_EXEC: begin
                if (res_go) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_rlen      = '0;
                    n_dcount    = '0;
                    n_obyte     = '0;
                    n_last      = 1'b0;
                    case (r_kind)
                        KIND_MSG_START: begin
                            if (r_msg_open) begin
                                n_status = ST_BUSY;
                            end else if (r_capture_on && r_mlen != '0) begin
                                if (need > NEEDW'(free_bytes)) begin
                                    n_dropped = drop_sum[DCNT_W] ? '1 : drop_sum[DCNT_W-1:0];
                                    n_status  = ST_DROPPED;
                                end else begin
                                    n_msg_open   = 1'b1;
                                    n_msg_left   = r_mlen;
                                    n_chunk_left = '0;
                                end
                            end
                        end
                        KIND_MSG_BYTE: begin
                            if (!r_msg_open) begin
                                n_status = ST_NONE_OPEN;
                            end else begin
                                mem_we       = 1'b1;
                                n_wr_ptr     = f_wrap(r_wr_ptr, UW'(1));
                                n_used       = r_used + UW'(1);
                                n_chunk_left = r_chunk_left - CW'(1);
                                n_msg_left   = r_msg_left - MLEN_W'(1);
                                if (r_msg_left == MLEN_W'(1)) begin
                                    n_msg_open   = 1'b0;
                                    n_chunk_left = '0;
                                end
                            end
                        end
                        KIND_POP_START: begin
                            n_dcount  = r_dropped;
                            n_dropped = '0;
                            if (r_msg_open) begin
                                n_status = ST_BUSY;
                            end else if (r_used < UW'(HEADER_BYTES)) begin
                                n_status = ST_EMPTY;
                            end else if (r_hdr > HDR_W'(r_cap) ||
                                         r_hdr > HDR_W'(r_used) - HDR_W'(HEADER_BYTES)) begin
                                // header stays in place
                                n_status = ST_TOO_LARGE;
                            end else begin
                                n_rd_ptr   = f_wrap(r_rd_ptr, UW'(HEADER_BYTES));
                                n_used     = r_used - UW'(HEADER_BYTES);
                                n_rec_left = CW'(r_hdr);
                                n_rec_open = (r_hdr != '0);
                                n_status   = ST_READY;
                                n_rlen     = r_hdr[RLEN_W-1:0];
                            end
                        end
                        default: begin
                            if (!r_rec_open || r_rec_left == '0 || r_used == '0) begin
                                n_status = ST_NONE_OPEN;
                            end else begin
                                n_obyte    = mem_rdata;
                                n_rd_ptr   = f_wrap(r_rd_ptr, UW'(1));
                                n_used     = r_used - UW'(1);
                                n_rec_left = r_rec_left - CW'(1);
                                if (r_rec_left == CW'(1)) begin
                                    n_rec_open = 1'b0;
                                    n_last     = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_used       <= '0;
            r_dropped    <= '0;
            r_msg_left   <= '0;
            r_chunk_left <= '0;
            r_rec_left   <= '0;
            r_msg_open   <= 1'b0;
            r_rec_open   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_used       <= n_used;
            r_dropped    <= n_dropped;
            r_msg_left   <= n_msg_left;
            r_chunk_left <= n_chunk_left;
            r_rec_left   <= n_rec_left;
            r_msg_open   <= n_msg_open;
            r_rec_open   <= n_rec_open;
            r_out_valid  <= n_out_valid;
        end
    end

    // command capture, admission product, header assembly, result payload
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_kind <= i_req.kind;
            r_mlen <= i_req.message_length;
            r_byte <= i_req.in_byte;
            r_cap  <= i_req.reader_capacity;
        end
        if (r_state == S_MUL) begin
            r_prod <= PRODW'(r_mlen - MLEN_W'(1)) * PRODW'(RECIP[MULW-1:0]);
        end
        if (r_state == S_HRD && r_cnt != 3'd0) begin
            r_hdr[8*hdr_idx +: 8] <= mem_rdata;
        end
        r_status <= n_status;
        r_rlen   <= n_rlen;
        r_dcount <= n_dcount;
        r_obyte  <= n_obyte;
        r_last   <= n_last;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.rec_len       = r_rlen;
    assign o_rsp.dropped_count = r_dcount;
    assign o_rsp.out_byte      = r_obyte;
    assign o_rsp.last          = r_last;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_on <= 1'b0;
        end else if (cfg_write && paddr[PADDR_W-1:2] == REG_CAPTURE_ON) begin
            r_capture_on <= pwdata[0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_CAPTURE_ON) ? PDATA_W'(r_capture_on) : '0;

endmodule

>>> sim/length_prefixed_record_fifo_tb.sv
module length_prefixed_record_fifo_tb;
    import lprf_pkg::*;

    localparam int QB = QUEUE_BYTES_DEF;
    localparam int RB = RECORD_BYTES_DEF;
    localparam logic [MLEN_W-1:0] LEN_MAX = '1;
    localparam logic [CAP_W-1:0]  CAP_MAX = '1;

    typedef struct packed {
        t_kind               kind;
        logic [MLEN_W-1:0]   mlen;
        logic [BYTE_W-1:0]   data;
        logic [CAP_W-1:0]    cap;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [RLEN_W-1:0]   rlen;
        logic [DCNT_W-1:0]   drops;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lprf_req_if req_ch ();
    lprf_rsp_if rsp_ch ();

    length_prefixed_record_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // commands waiting for the driver, results waiting for the monitor
    t_cmd    cmd_q[$];
    t_result result_q[$];

    int errors  = 0;
    int added   = 0;        // commands queued so far
    int checked = 0;        // result transfers seen so far
    bit no_idle = 1'b0;     // set for the final stretch: no gaps, no stalls

    // ------------------------------------------------------------------
    // Shadow of the ring FIFO
    // ------------------------------------------------------------------
    logic [7:0]  ring [QB];
    int unsigned rd_ptr     = 0;
    int unsigned wr_ptr     = 0;
    int unsigned used_cnt   = 0;
    int unsigned msg_left   = 0;
    int unsigned chunk_left = 0;
    int unsigned rec_left   = 0;
    logic [31:0] drop_sum   = '0;
    bit          msg_open   = 1'b0;
    bit          rec_open   = 1'b0;
    bit          capture    = 1'b0;

    function automatic void ring_push(logic [7:0] b);
        ring[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % QB;
        used_cnt++;
    endfunction

    // little-endian length header starting at ring offset p
    function automatic logic [31:0] header_at(int unsigned p);
        return {ring[(p + 3) % QB], ring[(p + 2) % QB], ring[(p + 1) % QB], ring[p % QB]};
    endfunction

    // Applies one command to the shadow and returns the result it should give.
    function automatic t_result fifo_step(t_cmd c);
        t_result     r;
        int unsigned m;
        int unsigned chunks;
        int unsigned need;
        int unsigned n;
        logic [32:0] sum;
        logic [31:0] hdr;
        r = '0;
        r.status = ST_OK;
        m = 32'(c.mlen);
        case (c.kind)
            KIND_MSG_START: begin
                if (msg_open) begin
                    r.status = ST_BUSY;
                end else if (capture && m != 0) begin
                    chunks = (m - 1) / RB + 1;
                    need = m + chunks * HEADER_BYTES;
                    if (need > QB - used_cnt) begin
                        // drop counter saturates at all ones
                        sum = {1'b0, drop_sum} + 33'(m);
                        drop_sum = sum[32] ? '1 : sum[31:0];
                        r.status = ST_DROPPED;
                    end else begin
                        msg_open = 1'b1;
                        msg_left = m;
                        chunk_left = 0;
                    end
                end
            end
            KIND_MSG_BYTE: begin
                if (!msg_open) begin
                    r.status = ST_NONE_OPEN;
                end else begin
                    // first byte of a chunk brings its header along
                    if (chunk_left == 0) begin
                        n = (msg_left > RB) ? RB : msg_left;
                        for (int i = 0; i < HEADER_BYTES; i++)
                            ring_push(8'(n >> (8 * i)));
                        chunk_left = n;
                    end
                    ring_push(c.data);
                    chunk_left--;
                    msg_left--;
                    if (msg_left == 0) begin
                        msg_open = 1'b0;
                        chunk_left = 0;
                    end
                end
            end
            KIND_POP_START: begin
                r.drops = drop_sum;
                drop_sum = '0;
                if (msg_open) begin
                    r.status = ST_BUSY;
                end else begin
                    // unread tail of the open record is thrown away
                    if (rec_open) begin
                        n = (rec_left > used_cnt) ? used_cnt : rec_left;
                        rd_ptr = (rd_ptr + n) % QB;
                        used_cnt -= n;
                        rec_left = 0;
                        rec_open = 1'b0;
                    end
                    if (used_cnt < HEADER_BYTES) begin
                        r.status = ST_EMPTY;
                    end else begin
                        hdr = header_at(rd_ptr);
                        if (hdr > 32'(c.cap) || hdr > used_cnt - HEADER_BYTES) begin
                            r.status = ST_TOO_LARGE;     // header stays in place
                        end else begin
                            rd_ptr = (rd_ptr + HEADER_BYTES) % QB;
                            used_cnt -= HEADER_BYTES;
                            rec_left = hdr;
                            rec_open = (hdr != 0);
                            r.status = ST_READY;
                            r.rlen = hdr[RLEN_W-1:0];
                        end
                    end
                end
            end
            default: begin
                if (!rec_open || rec_left == 0 || used_cnt == 0) begin
                    r.status = ST_NONE_OPEN;
                end else begin
                    r.data = ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % QB;
                    used_cnt--;
                    rec_left--;
                    if (rec_left == 0) begin
                        rec_open = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Request driver: one command per transfer, random gap bursts between
    // commands. The shadow is stepped at the edge the transfer happens.
    // ------------------------------------------------------------------
    t_cmd cur;
    int   gap_left = 0;

    always @(posedge i_clk) begin
        bit next_valid;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                result_q.push_back(fifo_step(cur));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() > 0) begin
                    if (!no_idle && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(0, 4);   // random idle gap before the next command
                    end else begin
                        cur = cmd_q.pop_front();
                        req_ch.kind            <= cur.kind;
                        req_ch.message_length  <= cur.mlen;
                        req_ch.in_byte         <= cur.data;
                        req_ch.reader_capacity <= cur.cap;
                        next_valid = 1'b1;
                    end
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every result transfer is matched against the oldest
    // prediction, field by field. Ready drops in random stall bursts.
    // ------------------------------------------------------------------
    int stall_left = 0;

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                checked++;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, rsp_ch.status);
                end else begin
                    want = result_q.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("rec_len", 32'(want.rlen), 32'(rsp_ch.rec_len));
                    check_field("dropped_count", want.drops, rsp_ch.dropped_count);
                    check_field("out_byte", 32'(want.data), 32'(rsp_ch.out_byte));
                    check_field("last", 32'(want.last), 32'(rsp_ch.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one command; v goes to the field its kind uses, the other
    // fields carry random junk that the block must ignore.
    function automatic void add(t_kind k, int unsigned v);
        t_cmd c;
        c.kind = k;
        c.mlen = MLEN_W'($urandom);
        c.data = BYTE_W'($urandom);
        c.cap  = CAP_W'($urandom);
        case (k)
            KIND_MSG_START: c.mlen = MLEN_W'(v);
            KIND_MSG_BYTE:  c.data = BYTE_W'(v);
            KIND_POP_START: c.cap  = CAP_W'(v);
            default: ;
        endcase
        cmd_q.push_back(c);
        added++;
    endfunction

    // all queued work done and every result back
    task automatic wait_idle();
        while (checked < added)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write, then read back through the same port
    task automatic reg_write(logic [PIDX_W-1:0] idx, bit v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W-1){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);           // write transfer at this edge
        capture = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);           // read access phase ends here
        if (prdata !== {{(PDATA_W-1){1'b0}}, v}) begin
            errors++;
            $display("%0t: capture_on readback mismatch, expected %0h, actual %0h",
                     $time, v, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Well-formed message with a few busy commands mixed in.
    function automatic void message_seq(int unsigned len);
        add(KIND_MSG_START, len);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 14) == 0)
                add(KIND_POP_START, $urandom);
            if ($urandom_range(0, 29) == 0)
                add(KIND_MSG_START, $urandom_range(1, 64));
            add(KIND_MSG_BYTE, $urandom);
        end
    endfunction

    // Pop start followed by a random number of pop bytes; may stop short
    // (tail gets discarded later) or run past the end (nothing open).
    function automatic void pop_seq();
        int unsigned sel;
        logic [CAP_W-1:0] cap;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            cap = CAP_MAX;
        else if (sel < 17)
            cap = CAP_W'($urandom_range(0, 40));
        else
            cap = CAP_W'($urandom);
        add(KIND_POP_START, cap);
        repeat ($urandom_range(0, 30)) add(KIND_POP_BYTE, 0);
    endfunction

    function automatic void random_phase(int n);
        int target;
        int unsigned pick;
        target = added + n;
        while (added < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                message_seq($urandom_range(1, 24));
            end else if (pick < 18) begin
                pop_seq();
            end else begin
                add(t_kind'($urandom_range(0, 3)), $urandom);
            end
        end
    endfunction

    // Finish any open message, then read every stored record in full.
    // Record lengths come from the shadow, which is exact while idle.
    task automatic drain();
        int unsigned p;
        int unsigned left;
        int unsigned skip;
        int unsigned len;
        wait_idle();
        if (msg_open) begin
            repeat (msg_left) add(KIND_MSG_BYTE, $urandom);
            wait_idle();
        end
        p = rd_ptr;
        left = used_cnt;
        if (rec_open) begin
            skip = (rec_left > left) ? left : rec_left;
            p = (p + skip) % QB;
            left -= skip;
        end
        while (left >= HEADER_BYTES) begin
            len = header_at(p);
            add(KIND_POP_START, CAP_MAX);
            repeat (len) add(KIND_POP_BYTE, 0);
            p = (p + HEADER_BYTES + len) % QB;
            left -= HEADER_BYTES + len;
        end
        add(KIND_POP_START, CAP_MAX);        // should now answer empty
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_ch.valid           = 1'b0;
        req_ch.kind            = KIND_MSG_START;
        req_ch.message_length  = '0;
        req_ch.in_byte         = '0;
        req_ch.reader_capacity = '0;
        rsp_ch.ready           = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // capture off out of reset: starts are ignored, nothing to read
        add(KIND_MSG_START, 5);
        add(KIND_MSG_BYTE, 8'h3C);
        add(KIND_POP_START, 0);
        add(KIND_POP_BYTE, 0);
        wait_idle();

        // capture on: zero length, drop, busy start, busy pop, too large,
        // full read with last, stray bytes, discard of an unread tail
        reg_write(REG_CAPTURE_ON, 1'b1);
        add(KIND_MSG_START, 0);
        add(KIND_MSG_START, LEN_MAX);
        add(KIND_MSG_START, 3);
        add(KIND_MSG_START, 5);
        add(KIND_POP_START, CAP_MAX);
        add(KIND_MSG_BYTE, 8'h00);
        add(KIND_MSG_BYTE, 8'hFF);
        add(KIND_MSG_BYTE, 8'h5A);
        add(KIND_MSG_BYTE, 8'h11);
        add(KIND_POP_START, 2);
        add(KIND_POP_START, 3);
        repeat (4) add(KIND_POP_BYTE, 0);
        add(KIND_MSG_START, 4);
        repeat (4) add(KIND_MSG_BYTE, $urandom);
        add(KIND_POP_START, CAP_MAX);
        add(KIND_POP_BYTE, 0);
        add(KIND_POP_START, CAP_MAX);
        wait_idle();

        // capture switched off halfway through an admitted message
        add(KIND_MSG_START, 6);
        repeat (3) add(KIND_MSG_BYTE, $urandom);
        wait_idle();
        reg_write(REG_CAPTURE_ON, 1'b0);
        repeat (3) add(KIND_MSG_BYTE, $urandom);
        add(KIND_MSG_START, 2);
        add(KIND_MSG_BYTE, $urandom);
        add(KIND_POP_START, CAP_MAX);
        repeat (6) add(KIND_POP_BYTE, 0);
        wait_idle();
        reg_write(REG_CAPTURE_ON, 1'b1);

        // drop counter saturation
        repeat (260) add(KIND_MSG_START, LEN_MAX);
        add(KIND_POP_START, CAP_MAX);
        add(KIND_POP_START, CAP_MAX);
        wait_idle();

        random_phase(80);
        drain();

        // empty ring, four chunks: one byte more than fits is dropped
        add(KIND_MSG_START, QB - 4 * HEADER_BYTES + 1);
        add(KIND_POP_START, CAP_MAX);
        wait_idle();

        // short stretch with capture off
        reg_write(REG_CAPTURE_ON, 1'b0);
        random_phase(20);
        drain();
        reg_write(REG_CAPTURE_ON, 1'b1);

        random_phase(40);
        wait_idle();
        no_idle = 1'b1;
        random_phase(40);
        drain();

        if (errors == 0) begin
            $display("length_prefixed_record_fifo_tb: clean");
        end else begin
            $display("length_prefixed_record_fifo_tb: errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #30000000;
        $display("length_prefixed_record_fifo_tb: errors");
        $finish;
    end

endmodule
